FILE: rtl/drvm_pkg.sv
// ----------------------------------------------------------------------------
// drvm_pkg: shared types and constants for the delayed RMS volume meter
// Queue geometry, register indexes, opcodes and the sequencer state type.
// ----------------------------------------------------------------------------
package drvm_pkg;

    localparam int QUEUE_DEPTH = 4096;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS     = 1'd1;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [15:0] ALPHA_Q16 = 16'd13107;

    typedef struct packed {
        logic        opcode;
        logic [15:0] sample_value;
        logic [31:0] time_now;
        logic [12:0] window_length;
    } req_t;

    typedef struct packed {
        logic [15:0] volume;
        logic [15:0] level_average;
        logic [12:0] queued_count;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV,
        ST_SQRT1,
        ST_EMA,
        ST_SQRT2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } sqrt_ctl_t;

endpackage

FILE: rtl/drvm_if.sv
// ----------------------------------------------------------------------------
// drvm_if: valid/ready channel carrying one payload
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface drvm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/drvm_sqrt.sv
// ----------------------------------------------------------------------------
// drvm_sqrt: iterative integer square root
// Floor root of a 48-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module drvm_sqrt
(
    input  logic                clk,
    input  logic                rst_n,
    input  drvm_pkg::sqrt_ctl_t ctl,
    input  logic [47:0]         radicand,
    output logic                done,
    output logic [23:0]         root
);

    logic [47:0] rem_reg, rem_next;
    logic [23:0] res_reg, res_next;
    logic [4:0]  step_reg, step_next;
    logic        run_reg, run_next;
    logic [49:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        step_next = step_reg;
        run_next  = run_reg;
        trial     = '0;
        if (ctl.start)
        begin
            rem_next  = radicand;
            res_next  = '0;
            step_next = 5'd23;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // trial = (2*res + 2^step) << step, res holds only bits above step
            trial = ({25'd0, res_reg, 1'b0} + (50'd1 << step_reg)) << step_reg;
            if ({2'b00, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[47:0];
                res_next = res_reg | (24'd1 << step_reg);
            end
            if (step_reg == 5'd0)
                run_next = 1'b0;
            else
                step_next = step_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = ctl.busy && !run_reg && !ctl.start;
    assign root = res_reg;

endmodule

FILE: rtl/delayed_rms_volume_meter.sv
// ----------------------------------------------------------------------------
// delayed_rms_volume_meter: delayed RMS level meter with moving average
// Queues timestamped samples; update requests drain aged samples, take the
// RMS, smooth it and produce a square-root volume.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  req      | in  | opcode, sample_value, time_now, window_length
//  rsp      | out | volume, level_average, queued_count
//  cfg      | in  | cfg_we, cfg_idx, cfg_data (0 threshold, 1 delay)
//
// A push goes straight to the done state and then to the output handshake.
// An update steps through queue memory read, age check, square and accumulate
// for each drained sample, then the divider and the two square roots.
// Reset clears pointers, fill count and levels; no clearing pass.
// req is not ready while a request is in work or a response waits.
module delayed_rms_volume_meter
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    drvm_if.sink                                   req,
    drvm_if.source                                 rsp,
    input  logic                                   cfg_we,
    input  logic [drvm_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  logic [drvm_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int PW = drvm_pkg::PTR_W;
    localparam int CW = drvm_pkg::CNT_W;

    drvm_pkg::state_t state_reg, state_next;

    logic [15:0]   sample_mem [drvm_pkg::QUEUE_DEPTH];
    logic [31:0]   stamp_mem  [drvm_pkg::QUEUE_DEPTH];
    logic [15:0]   rd_sample_reg;
    logic [31:0]   rd_stamp_reg;

    logic [PW-1:0] rptr_reg, rptr_next;
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [15:0]   avg_reg, avg_next;
    logic [15:0]   vol_reg, vol_next;
    logic [11:0]   thr_reg;
    logic [31:0]   delay_reg;

    drvm_pkg::req_t item_reg;
    logic [12:0]   taken_reg, taken_next;
    logic [31:0]   sq_reg, sq_next;
    logic [43:0]   sum_reg, sum_next;
    // restoring divider: quotient shifts into sum_reg
    logic [12:0]   drem_reg, drem_next;
    logic [5:0]    dcnt_reg, dcnt_next;
    logic [15:0]   rms_reg, rms_next;

    logic          mem_we;
    logic          mem_re;
    logic          fire;
    logic          rsp_valid_reg, rsp_valid_next;

    drvm_pkg::sqrt_ctl_t sq_ctl;
    logic [47:0]   sq_in;
    logic          sq_done;
    logic [23:0]   sq_root;

    logic signed [15:0] smp;
    logic [31:0]   age;
    logic [13:0]   dtrial;
    logic [16:0]   diff;
    logic [32:0]   prod;
    logic [16:0]   step;

    assign fire      = req.valid && req.ready;
    assign req.ready = (state_reg == drvm_pkg::ST_IDLE) && !rsp_valid_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload.volume        = vol_reg;
    assign rsp.payload.level_average = avg_reg;
    assign rsp.payload.queued_count  = fill_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            drvm_pkg::ST_IDLE:
                if (fire)
                    state_next = (req.payload.opcode == drvm_pkg::OP_PUSH) ?
                                 drvm_pkg::ST_DONE : drvm_pkg::ST_READ;
            drvm_pkg::ST_READ:
                if (taken_reg >= item_reg.window_length || fill_reg == '0)
                    state_next = drvm_pkg::ST_DIV;
                else
                    state_next = drvm_pkg::ST_CHECK;
            drvm_pkg::ST_CHECK:
                state_next = (age < delay_reg) ? drvm_pkg::ST_DIV : drvm_pkg::ST_SQUARE;
            drvm_pkg::ST_SQUARE: state_next = drvm_pkg::ST_ACCUM;
            drvm_pkg::ST_ACCUM:  state_next = drvm_pkg::ST_READ;
            drvm_pkg::ST_DIV:
                if (item_reg.window_length == '0)
                    state_next = drvm_pkg::ST_EMA;
                else if (dcnt_reg == 6'd0)
                    state_next = drvm_pkg::ST_SQRT1;
            drvm_pkg::ST_SQRT1:
                if (sq_done)
                    state_next = drvm_pkg::ST_EMA;
            drvm_pkg::ST_EMA:    state_next = drvm_pkg::ST_SQRT2;
            drvm_pkg::ST_SQRT2:
                if (sq_done)
                    state_next = drvm_pkg::ST_DONE;
            drvm_pkg::ST_DONE:   state_next = drvm_pkg::ST_IDLE;
            default:             state_next = drvm_pkg::ST_IDLE;
        endcase
    end

    assign smp    = rd_sample_reg;
    assign age    = item_reg.time_now - rd_stamp_reg;
    assign dtrial = {drem_reg, sum_reg[43]};
    assign diff   = (rms_reg >= avg_reg) ? {1'b0, rms_reg} - {1'b0, avg_reg}
                                         : {1'b0, avg_reg} - {1'b0, rms_reg};
    assign prod   = diff * drvm_pkg::ALPHA_Q16;

    // outputs / datapath
    always_comb
    begin
        rptr_next      = rptr_reg;
        wptr_next      = wptr_reg;
        fill_next      = fill_reg;
        avg_next       = avg_reg;
        vol_next       = vol_reg;
        taken_next     = taken_reg;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        drem_next      = drem_reg;
        dcnt_next      = dcnt_reg;
        rms_next       = rms_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        sq_ctl         = '0;
        sq_in          = '0;
        step           = '0;
        if (rsp.valid && rsp.ready)
            rsp_valid_next = 1'b0;
        unique case (state_reg)
            drvm_pkg::ST_IDLE:
                if (fire)
                begin
                    taken_next = '0;
                    sum_next   = '0;
                    if (req.payload.opcode == drvm_pkg::OP_PUSH)
                    begin
                        if (fill_reg >= CW'(drvm_pkg::QUEUE_DEPTH) ||
                            fill_reg + 1'b1 > {1'b0, thr_reg})
                        begin
                            rptr_next = '0;
                            wptr_next = '0;
                            fill_next = '0;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            wptr_next = wptr_reg + 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                end
            drvm_pkg::ST_READ:
            begin
                mem_re    = 1'b1;
                dcnt_next = 6'd44;
                drem_next = '0;
            end
            drvm_pkg::ST_CHECK: ;
            drvm_pkg::ST_SQUARE:
                sq_next = 32'($signed(smp) * $signed(smp));
            drvm_pkg::ST_ACCUM:
            begin
                sum_next   = sum_reg + {12'd0, sq_reg};
                rptr_next  = rptr_reg + 1'b1;
                fill_next  = fill_reg - 1'b1;
                taken_next = taken_reg + 1'b1;
            end
            drvm_pkg::ST_DIV:
                if (item_reg.window_length == '0)
                    rms_next = '0;
                else if (dcnt_reg != 6'd0)
                begin
                    dcnt_next = dcnt_reg - 6'd1;
                    if (dtrial >= {1'b0, item_reg.window_length})
                    begin
                        drem_next = 13'(dtrial - {1'b0, item_reg.window_length});
                        sum_next  = {sum_reg[42:0], 1'b1};
                    end
                    else
                    begin
                        drem_next = dtrial[12:0];
                        sum_next  = {sum_reg[42:0], 1'b0};
                    end
                end
                else
                begin
                    sq_ctl.start = 1'b1;
                    sq_in        = {4'd0, sum_reg};
                end
            drvm_pkg::ST_SQRT1:
            begin
                sq_ctl.busy = 1'b1;
                if (sq_done)
                    rms_next = sq_root[15:0];
            end
            drvm_pkg::ST_EMA:
            begin
                if (rms_reg >= avg_reg)
                    avg_next = avg_reg + prod[31:16];
                else
                begin
                    step = prod[32:16] + {16'd0, prod[15:0] != 16'd0};
                    avg_next = (step > {1'b0, avg_reg}) ? 16'd0 : 16'(avg_reg - step);
                end
            end
            drvm_pkg::ST_SQRT2:
            begin
                sq_ctl.busy = 1'b1;
                if (sq_done)
                    vol_next = sq_root[15:0];
            end
            drvm_pkg::ST_DONE:
                rsp_valid_next = 1'b1;
            default: ;
        endcase
        if (state_reg == drvm_pkg::ST_EMA)
        begin
            sq_ctl.start = 1'b1;
            sq_in = (avg_next > 16'd8192) ? 48'd32768 << 15
                                          : {30'd0, avg_next, 2'b00} << 15;
        end
    end

    drvm_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sq_ctl),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[wptr_reg] <= req.payload.sample_value;
            stamp_mem[wptr_reg]  <= req.payload.time_now;
        end
        if (mem_re)
        begin
            rd_sample_reg <= sample_mem[rptr_reg];
            rd_stamp_reg  <= stamp_mem[rptr_reg];
        end
        if (fire)
            item_reg <= req.payload;
        taken_reg <= taken_next;
        sq_reg    <= sq_next;
        sum_reg   <= sum_next;
        drem_reg  <= drem_next;
        dcnt_reg  <= dcnt_next;
        rms_reg   <= rms_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drvm_pkg::ST_IDLE;
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            fill_reg      <= '0;
            avg_reg       <= '0;
            vol_reg       <= '0;
            thr_reg       <= 12'd4095;
            delay_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rptr_reg      <= rptr_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
            avg_reg       <= avg_next;
            vol_reg       <= vol_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we && cfg_idx == drvm_pkg::REG_CLEAR_THRESHOLD)
                thr_reg <= cfg_data[11:0];
            if (cfg_we && cfg_idx == drvm_pkg::REG_DELAY_TICKS)
                delay_reg <= cfg_data;
        end
    end

endmodule

FILE: rtl/drvm_checker.sv
// ----------------------------------------------------------------------------
// drvm_checker: port-level checks for the volume meter
// Watches the request and response handshakes and result ranges.
// ----------------------------------------------------------------------------
module drvm_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input drvm_pkg::rsp_t        rsp_payload
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("response dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while response pending");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready right after accept");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_payload.volume <= 16'd32768 &&
                      rsp_payload.queued_count <= 13'd4096)
        else $error("result out of range");

endmodule

bind delayed_rms_volume_meter drvm_checker u_drvm_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

FILE: tb/sv/tb_delayed_rms_volume_meter.sv
// ----------------------------------------------------------------------------
// tb_delayed_rms_volume_meter: self-checking bench for the RMS volume meter
// Directed rows, then randomized phases under several threshold and delay
// settings. Responses are compared with a cycle-free level predictor, or with
// the fixed expected values of the typed directed rows.
module tb_delayed_rms_volume_meter;

    typedef struct {
        logic           op;
        logic [15:0]    smp;
        logic [31:0]    tick;
        logic [12:0]    win;
        bit             typed;
        drvm_pkg::rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [drvm_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [drvm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    drvm_if #(.T(drvm_pkg::req_t)) req_ch ();
    drvm_if #(.T(drvm_pkg::rsp_t)) rsp_ch ();

    delayed_rms_volume_meter dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [15:0] pend_sample [drvm_pkg::QUEUE_DEPTH];
    logic [31:0] pend_stamp  [drvm_pkg::QUEUE_DEPTH];
    logic [drvm_pkg::PTR_W-1:0] head_ptr, tail_ptr;
    int unsigned queued;
    int unsigned avg_lvl, vol_lvl;
    int unsigned thresh;
    logic [31:0] min_age;

    drvm_pkg::rsp_t level_queue[$];
    int   mismatches = 0;
    bit   quiet = 1'b0;
    bit   hold_request = 1'b0;
    logic [31:0] tick_now;

    dir_row_t dir_rows[12] = '{
        '{drvm_pkg::OP_PUSH,   16'h0000, 32'd0,         13'd0,    1'b1, '{16'd0, 16'd0, 13'd1}},
        '{drvm_pkg::OP_UPDATE, 16'h0000, 32'd1,         13'd0,    1'b1, '{16'd0, 16'd0, 13'd1}},
        '{drvm_pkg::OP_PUSH,   16'h7FFF, 32'd2,         13'd0,    1'b0, '{16'd0, 16'd0, 13'd0}},
        '{drvm_pkg::OP_PUSH,   16'h8000, 32'd3,         13'd0,    1'b0, '{16'd0, 16'd0, 13'd0}},
        '{drvm_pkg::OP_PUSH,   16'h0001, 32'd4,         13'd0,    1'b0, '{16'd0, 16'd0, 13'd0}},
        '{drvm_pkg::OP_UPDATE, 16'hFFFF, 32'd5,         13'd4,    1'b0, '{16'd0, 16'd0, 13'd0}},
        '{drvm_pkg::OP_UPDATE, 16'h0000, 32'd6,         13'h1FFF, 1'b0, '{16'd0, 16'd0, 13'd0}},
        '{drvm_pkg::OP_PUSH,   16'hFFFF, 32'hFFFF_FFFF, 13'h1FFF, 1'b0, '{16'd0, 16'd0, 13'd0}},
        '{drvm_pkg::OP_PUSH,   16'h8000, 32'd0,         13'd0,    1'b0, '{16'd0, 16'd0, 13'd0}},
        '{drvm_pkg::OP_UPDATE, 16'h0000, 32'd3,         13'h1000, 1'b0, '{16'd0, 16'd0, 13'd0}},
        '{drvm_pkg::OP_UPDATE, 16'h0000, 32'd4,         13'd0,    1'b0, '{16'd0, 16'd0, 13'd0}},
        '{drvm_pkg::OP_UPDATE, 16'h0000, 32'd5,         13'd1,    1'b0, '{16'd0, 16'd0, 13'd0}}
    };

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd16777215;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic drvm_pkg::rsp_t meter_step(drvm_pkg::req_t r);
        longint unsigned energy;
        longint signed   s;
        int unsigned     drained, level, step, full;
        drvm_pkg::rsp_t  o;
        if (r.opcode == drvm_pkg::OP_PUSH)
        begin
            if (queued >= drvm_pkg::QUEUE_DEPTH)
            begin
                head_ptr = '0; tail_ptr = '0; queued = 0;
            end
            else
            begin
                pend_sample[tail_ptr] = r.sample_value;
                pend_stamp[tail_ptr]  = r.time_now;
                tail_ptr = tail_ptr + 1'b1;
                queued++;
                if (queued > thresh)
                begin
                    head_ptr = '0; tail_ptr = '0; queued = 0;
                end
            end
        end
        else
        begin
            energy = 0;
            drained = 0;
            while (drained < r.window_length && queued > 0 &&
                   (r.time_now - pend_stamp[head_ptr]) >= min_age)
            begin
                s = $signed(pend_sample[head_ptr]);
                energy += longint'(s * s);
                head_ptr = head_ptr + 1'b1;
                queued--;
                drained++;
            end
            level = (r.window_length == 0) ? 0 :
                    int'(floor_root(energy / r.window_length));
            // upward steps round down, downward steps round away from zero
            if (level >= avg_lvl)
                avg_lvl += ((level - avg_lvl) * 13107) >> 16;
            else
            begin
                step = ((avg_lvl - level) * 13107 + 65535) >> 16;
                avg_lvl = (step > avg_lvl) ? 0 : avg_lvl - step;
            end
            full = avg_lvl * 4;
            if (full > 32768)
                full = 32768;
            vol_lvl = int'(floor_root(longint'(full) << 15));
        end
        o.volume        = vol_lvl[15:0];
        o.level_average = avg_lvl[15:0];
        o.queued_count  = queued[12:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_request(drvm_pkg::req_t item, bit typed, drvm_pkg::rsp_t want);
        drvm_pkg::rsp_t predicted;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        req_ch.payload = item;
        req_ch.valid   = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = meter_step(item);
        level_queue.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained;
        req_ch.valid = 1'b0;
        while (level_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [drvm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == drvm_pkg::REG_CLEAR_THRESHOLD)
            thresh = val[11:0];
        else
            min_age = val;
    endtask

    task automatic random_request(bit wild_time, bit long_hops);
        drvm_pkg::req_t r;
        int   pick;
        tick_now = tick_now + (long_hops ? $urandom_range(0, 300) : $urandom_range(0, 6));
        r.sample_value  = 16'($urandom);
        r.time_now      = wild_time && $urandom_range(0, 3) == 0 ? $urandom : tick_now;
        r.window_length = 13'($urandom);
        r.opcode        = ($urandom_range(0, 99) < 72) ? drvm_pkg::OP_PUSH
                                                       : drvm_pkg::OP_UPDATE;
        if (r.opcode == drvm_pkg::OP_UPDATE)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                r.window_length = '0;
            else if (pick == 1)
                r.window_length = 13'h1000;
            else if (pick < 17)
                r.window_length = 13'($urandom_range(1, queued + 4));
        end
        send_request(r, 1'b0, '0);
    endtask

    // response side: random backpressure, plus one long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp_ch.ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        drvm_pkg::rsp_t exp_rsp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (level_queue.size() == 0)
                report_mismatch("unexpected response, volume", rsp_ch.payload.volume, -1);
            else
            begin
                exp_rsp = level_queue[0];
                level_queue.delete(0);
                if (rsp_ch.payload.volume !== exp_rsp.volume)
                    report_mismatch("volume", rsp_ch.payload.volume, exp_rsp.volume);
                if (rsp_ch.payload.level_average !== exp_rsp.level_average)
                    report_mismatch("level_average", rsp_ch.payload.level_average,
                                    exp_rsp.level_average);
                if (rsp_ch.payload.queued_count !== exp_rsp.queued_count)
                    report_mismatch("queued_count", rsp_ch.payload.queued_count,
                                    exp_rsp.queued_count);
            end
        end
    end

    initial
    begin
        #20000000;
        $display("delayed_rms_volume_meter test failed");
        $finish;
    end

    initial
    begin
        drvm_pkg::req_t r;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        head_ptr = '0; tail_ptr = '0; queued = 0;
        avg_lvl = 0; vol_lvl = 0;
        thresh = 4095; min_age = '0;
        tick_now = 32'hFFFF_FF00;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            r.opcode        = dir_rows[i].op;
            r.sample_value  = dir_rows[i].smp;
            r.time_now      = dir_rows[i].tick;
            r.window_length = dir_rows[i].win;
            send_request(r, dir_rows[i].typed, dir_rows[i].want);
        end
        wait_drained();

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: begin write_reg(drvm_pkg::REG_CLEAR_THRESHOLD, 32'd0);
                         write_reg(drvm_pkg::REG_DELAY_TICKS, 32'd0); end
                1: write_reg(drvm_pkg::REG_CLEAR_THRESHOLD, 32'd1);
                2: begin write_reg(drvm_pkg::REG_CLEAR_THRESHOLD, 32'd12);
                         write_reg(drvm_pkg::REG_DELAY_TICKS, 32'd3); end
                3: begin write_reg(drvm_pkg::REG_CLEAR_THRESHOLD, 32'd4095);
                         write_reg(drvm_pkg::REG_DELAY_TICKS, 32'hFFFF_FFFF); end
                4: write_reg(drvm_pkg::REG_DELAY_TICKS, 32'd0);
                9: begin write_reg(drvm_pkg::REG_CLEAR_THRESHOLD, 32'd4095);
                         write_reg(drvm_pkg::REG_DELAY_TICKS, 32'd0); end
                default:
                begin
                    write_reg(drvm_pkg::REG_CLEAR_THRESHOLD, $urandom_range(2, 200));
                    write_reg(drvm_pkg::REG_DELAY_TICKS, $urandom_range(0, 400));
                end
            endcase
            if (phase == 5)
                hold_request = 1'b1;
            if (phase == 9)
                quiet = 1'b1;
            if (phase == 4)
            begin
                // long fill, then one full-length window
                for (int k = 0; k < 120; k++)
                begin
                    r = '0;
                    r.opcode = drvm_pkg::OP_PUSH;
                    r.sample_value = 16'($urandom);
                    r.time_now = tick_now;
                    send_request(r, 1'b0, '0);
                end
                r.opcode = drvm_pkg::OP_UPDATE;
                r.window_length = 13'h1000;
                send_request(r, 1'b0, '0);
            end
            else
            begin
                for (int k = 0; k < 55; k++)
                begin
                    random_request(phase == 3, phase >= 5);
                    // sender pause until everything is back
                    if (phase == 6 && k == 25)
                        wait_drained();
                end
            end
            wait_drained();
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("delayed_rms_volume_meter test passed");
        else
            $display("delayed_rms_volume_meter test failed");
        $finish;
    end

endmodule
